FILE: hw/rtl/crfop_pkg.sv
// ---------------------------------------------------------------------------
// crfop_pkg
// Shared codes and types for the command ring store with overwrite and
// push to the front.
// ---------------------------------------------------------------------------
package crfop_pkg;

  // operation codes carried in the kind field
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd0;
  localparam logic [1:0] KIND_POP        = 2'd1;
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

endpackage

FILE: hw/rtl/crfop_if.sv
// ---------------------------------------------------------------------------
// crfop_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface crfop_cmd_if #(
  parameter int ENTRY_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [ENTRY_WIDTH-1:0] entry_word;

  modport source (output valid, output kind, output entry_word, input ready);
  modport sink   (input valid, input kind, input entry_word, output ready);
endinterface

interface crfop_rsp_if #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FILL_WIDTH  = 5
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [ENTRY_WIDTH-1:0] popped_word;
  logic [FILL_WIDTH-1:0]  fill_level;

  modport source (output valid, output status, output popped_word, output fill_level,
                  input ready);
  modport sink   (input valid, input status, input popped_word, input fill_level,
                  output ready);
endinterface

FILE: hw/rtl/command_ring_fifo_overwrite_pushfront_top.sv
// ---------------------------------------------------------------------------
// command_ring_fifo_overwrite_pushfront_top
// Ring store of command words with overwrite when full and push to front.
// ---------------------------------------------------------------------------
// Each command beat gives exactly one result beat. A push to the back, a
// push to the front, an empty pop and the unused kind have their result in
// the output register in the cycle after acceptance; a successful pop first
// passes its entry through the store's registered read port. One command is
// in flight at a time; a new one is accepted as soon as the sequencer is idle
// and the output register is empty or is being drained in the same cycle.
// The entry store is a single memory with one write and one read port;
// entries are never read before a push writes them, so it needs no clearing.
module command_ring_fifo_overwrite_pushfront_top #(
  parameter int FIFO_DEPTH  = 16,
  parameter int ENTRY_WIDTH = 32,
  localparam int IDX_WIDTH  = $clog2(FIFO_DEPTH),
  localparam int FILL_WIDTH = IDX_WIDTH + 1
) (
  input  logic        clk,
  input  logic        rst,
  crfop_cmd_if.sink   cmd,
  crfop_rsp_if.source rsp
);

  crfop_pkg::state_t state;
  crfop_pkg::state_t state_next;

  logic [IDX_WIDTH-1:0]   head;
  logic [IDX_WIDTH-1:0]   tail;
  logic [FILL_WIDTH-1:0]  count;
  logic [IDX_WIDTH-1:0]   head_next;
  logic [IDX_WIDTH-1:0]   tail_next;
  logic [FILL_WIDTH-1:0]  count_next;

  logic                   out_valid;
  logic [1:0]             out_status;
  logic [ENTRY_WIDTH-1:0] out_word;
  logic [FILL_WIDTH-1:0]  out_fill;

  logic                   out_free;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   pop_hit;

  logic                   wr_en;
  logic [IDX_WIDTH-1:0]   wr_addr;
  logic                   rd_en;
  logic [ENTRY_WIDTH-1:0] rd_data;

  logic                   load_now;
  logic [1:0]             load_status;
  logic                   load_pop;

  // handshake
  assign out_free = !out_valid || rsp.ready;
  assign accept   = cmd.valid && cmd.ready;
  assign full     = (count == FILL_WIDTH'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_hit  = accept && (cmd.kind == crfop_pkg::KIND_POP) && !empty;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      crfop_pkg::ST_IDLE: begin
        if (pop_hit) begin
          state_next = crfop_pkg::ST_POP;
        end
      end
      crfop_pkg::ST_POP: begin
        state_next = crfop_pkg::ST_IDLE;
      end
      default: begin
        state_next = crfop_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd.ready = 1'b0;
    load_pop  = 1'b0;
    case (state)
      crfop_pkg::ST_IDLE: begin
        cmd.ready = out_free;
      end
      crfop_pkg::ST_POP: begin
        load_pop = 1'b1;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  // index, count and store access for the accepted command
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = tail;
    rd_en       = 1'b0;
    load_now    = 1'b0;
    load_status = crfop_pkg::STATUS_OK;
    if (accept) begin
      load_now = 1'b1;
      case (cmd.kind)
        crfop_pkg::KIND_PUSH_BACK, crfop_pkg::KIND_PUSH_FRONT: begin
          wr_en = 1'b1;
          if (full) begin
            // oldest entry is lost
            tail_next   = tail + 1'b1;
            head_next   = head + 1'b1;
            load_status = crfop_pkg::STATUS_FULL;
          end else if (cmd.kind == crfop_pkg::KIND_PUSH_BACK) begin
            tail_next  = tail + 1'b1;
            count_next = count + 1'b1;
          end else begin
            head_next  = head - 1'b1;
            wr_addr    = head - 1'b1;
            count_next = count + 1'b1;
          end
        end
        crfop_pkg::KIND_POP: begin
          if (empty) begin
            load_status = crfop_pkg::STATUS_EMPTY;
          end else begin
            // result is loaded once the read data returns
            rd_en      = 1'b1;
            load_now   = 1'b0;
            head_next  = head + 1'b1;
            count_next = count - 1'b1;
          end
        end
        default: begin
          load_status = crfop_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crfop_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (load_now || load_pop) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_pop) begin
      out_status <= crfop_pkg::STATUS_OK;
      out_word   <= rd_data;
      out_fill   <= count;
    end else if (load_now) begin
      out_status <= load_status;
      out_word   <= '0;
      out_fill   <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.popped_word = out_word;
  assign rsp.fill_level  = out_fill;

  crfop_store #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.entry_word),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

endmodule

FILE: hw/rtl/crfop_store.sv
// ---------------------------------------------------------------------------
// crfop_store
// Ring entry memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module crfop_store #(
  parameter int FIFO_DEPTH  = 16,
  parameter int ENTRY_WIDTH = 32,
  localparam int IDX_WIDTH  = $clog2(FIFO_DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [IDX_WIDTH-1:0]   wr_addr,
  input  logic [ENTRY_WIDTH-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [IDX_WIDTH-1:0]   rd_addr,
  output logic [ENTRY_WIDTH-1:0] rd_data
);

  logic [ENTRY_WIDTH-1:0] mem [FIFO_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: tb/sv/tb_command_ring_fifo_overwrite_pushfront_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_command_ring_fifo_overwrite_pushfront_top
// Self-checking bench for the command ring store. A directed table covers
// reset, extreme words, every kind, empty pops and overwrites when full;
// random segments then steer the fill level between empty and full. Every
// result beat is checked against a bench ring model or a fixed expectation.
// ---------------------------------------------------------------------------
module tb_command_ring_fifo_overwrite_pushfront_top;
  import crfop_pkg::*;

  localparam int DEPTH          = 16;
  localparam int WORD_W         = 32;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int FILL_W         = IDX_W + 1;
  localparam int RANDOM_ITEMS   = 700;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 40;

  // unused kind code, treated as a no-op by the block
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] popped_word;
    logic [FILL_W-1:0] fill_level;
  } ring_result_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] entry_word;
    logic              fixed;
    ring_result_t      want;
  } ring_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  crfop_cmd_if #(.ENTRY_WIDTH(WORD_W)) cmd ();
  crfop_rsp_if #(.ENTRY_WIDTH(WORD_W), .FILL_WIDTH(FILL_W)) rsp ();

  command_ring_fifo_overwrite_pushfront_top #(
    .FIFO_DEPTH (DEPTH),
    .ENTRY_WIDTH(WORD_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // bench copy of the ring
  logic [WORD_W-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]  ring_head = '0;
  logic [IDX_W-1:0]  ring_tail = '0;
  logic [FILL_W-1:0] ring_count = '0;

  ring_result_t pending_results[$];

  // typed expectation riding along with the current command beat
  logic         cmd_fixed = 1'b0;
  ring_result_t cmd_want = '0;

  bit send_idle_on = 1'b0;
  bit rsp_idle_on  = 1'b0;
  bit holdoff_req  = 1'b0;
  int fail_count   = 0;
  int report_count = 0;
  int quiet_cycles = 0;

  // apply one command to the bench ring and return the result it gives
  function automatic ring_result_t apply_ring_op(logic [1:0] kind, logic [WORD_W-1:0] word);
    ring_result_t res;
    logic         full;
    res = '0;
    res.status = STATUS_OK;
    full = (ring_count == DEPTH);
    case (kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) begin
          // oldest entry lost, both ends move on
          ring_mem[ring_tail] = word;
          ring_tail = ring_tail + 1'b1;
          ring_head = ring_head + 1'b1;
          res.status = STATUS_FULL;
        end else if (kind == KIND_PUSH_BACK) begin
          ring_mem[ring_tail] = word;
          ring_tail = ring_tail + 1'b1;
          ring_count = ring_count + 1'b1;
        end else begin
          ring_head = ring_head - 1'b1;
          ring_mem[ring_head] = word;
          ring_count = ring_count + 1'b1;
        end
      end
      KIND_POP: begin
        if (ring_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped_word = ring_mem[ring_head];
          ring_head = ring_head + 1'b1;
          ring_count = ring_count - 1'b1;
        end
      end
      default: ;
    endcase
    res.fill_level = ring_count;
    return res;
  endfunction

  function automatic ring_cmd_t make_cmd(logic [1:0] kind, logic [WORD_W-1:0] word,
                                         logic fixed = 1'b0, logic [1:0] status = STATUS_OK,
                                         logic [WORD_W-1:0] popped = '0,
                                         logic [FILL_W-1:0] fill = '0);
    ring_cmd_t c;
    c.kind = kind;
    c.entry_word = word;
    c.fixed = fixed;
    c.want.status = status;
    c.want.popped_word = popped;
    c.want.fill_level = fill;
    return c;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(string field, logic [WORD_W-1:0] want_v,
                                      logic [WORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (report_count < MAX_REPORTS) begin
        report_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      end
    end
  endfunction

  // offer one command beat and hold it until accepted
  task automatic send_cmd(ring_cmd_t c);
    int gap;
    gap = send_idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      cmd.valid = 1'b0;
    end
    @(negedge clk);
    cmd.valid = 1'b1;
    cmd.kind = c.kind;
    cmd.entry_word = c.entry_word;
    cmd_fixed = c.fixed;
    cmd_want = c.want;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // record expectations on accepted commands, compare accepted results
  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        want = apply_ring_op(cmd.kind, cmd.entry_word);
        if (cmd_fixed) want = cmd_want;
        pending_results.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: result beat with none expected, expected none, actual %0h/%0h/%0h",
                     $time, rsp.status, rsp.popped_word, rsp.fill_level);
          end
        end else begin
          want = pending_results.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
          check_field("popped_word", want.popped_word, rsp.popped_word);
          check_field("fill_level", WORD_W'(want.fill_level), WORD_W'(rsp.fill_level));
        end
      end
    end
  end

  // watchdog on stretches with no beat on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : rsp_drive
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        rsp.ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      stall = rsp_idle_on ? pick_gap() : 0;
      if (stall > 0) begin
        rsp.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    ring_cmd_t  directed[$];
    ring_cmd_t  c;
    logic [1:0] kind;
    int         sent;
    int         seg_len;
    int         mode;
    int         r;
    bit         holdoff_done;

    cmd.valid = 1'b0;
    cmd.kind = KIND_PUSH_BACK;
    cmd.entry_word = '0;
    sent = 0;
    holdoff_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: empty, no-op, extreme words, wrap of the head,
    // fill to full, overwrite by both pushes
    directed.push_back(make_cmd(KIND_POP, '0, 1'b1, STATUS_EMPTY, '0, '0));
    directed.push_back(make_cmd(KIND_NOP, '1, 1'b1, STATUS_OK, '0, '0));
    directed.push_back(make_cmd(KIND_PUSH_BACK, '1, 1'b1, STATUS_OK, '0, FILL_W'(1)));
    directed.push_back(make_cmd(KIND_PUSH_FRONT, '0, 1'b1, STATUS_OK, '0, FILL_W'(2)));
    directed.push_back(make_cmd(KIND_POP, '1, 1'b1, STATUS_OK, '0, FILL_W'(1)));
    directed.push_back(make_cmd(KIND_POP, '0, 1'b1, STATUS_OK, '1, '0));
    directed.push_back(make_cmd(KIND_POP, '0, 1'b1, STATUS_EMPTY, '0, '0));
    directed.push_back(make_cmd(KIND_PUSH_FRONT, 32'hA5A5_A5A5));
    for (int i = 1; i < DEPTH; i++) begin
      directed.push_back(make_cmd(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                                  32'h5555_5555 ^ (32'h1 << (2 * i))));
    end
    directed.push_back(make_cmd(KIND_PUSH_BACK, 32'h0F0F_0F0F, 1'b1, STATUS_FULL, '0,
                                FILL_W'(DEPTH)));
    directed.push_back(make_cmd(KIND_PUSH_FRONT, 32'hF0F0_F0F0, 1'b1, STATUS_FULL, '0,
                                FILL_W'(DEPTH)));
    directed.push_back(make_cmd(KIND_NOP, '0, 1'b1, STATUS_OK, '0, FILL_W'(DEPTH)));
    directed.push_back(make_cmd(KIND_POP, '0));
    directed.push_back(make_cmd(KIND_POP, '0));
    foreach (directed[i]) send_cmd(directed[i]);

    // random segments: push-heavy, pop-heavy or balanced
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      send_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(20, 60);
      for (int j = 0; j < seg_len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          kind = KIND_NOP;
        end else if (r < (mode == 0 ? 85 : (mode == 1 ? 30 : 55))) begin
          kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end else begin
          kind = KIND_POP;
        end
        r = $urandom_range(0, 99);
        c = make_cmd(kind, (r < 10) ? '0 : ((r < 20) ? '1 : $urandom()));
        send_cmd(c);
        if (kind != KIND_NOP) sent++;
        // long result stall while commands keep coming
        if (!holdoff_done && sent >= RANDOM_ITEMS / 2) begin
          holdoff_done = 1'b1;
          holdoff_req = 1'b1;
        end
      end
    end
    @(negedge clk);
    cmd.valid = 1'b0;

    // drain, then give stray results a chance to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
